// ----- hdl/rpcs_pkg.sv -----
`timescale 1ns / 1ps

package rpcs_pkg;

    localparam int PIX_W    = 8;
    localparam int MODE_W   = 2;
    localparam int IDX_W    = 3;
    localparam int NCH      = 3;
    localparam int SEG_N    = 5;
    localparam int SEG_W    = 3;
    localparam int FRAC_W   = 16;
    localparam int QPOS     = 32;
    localparam int U_W      = PIX_W + 2;
    localparam int KF_W     = 24;
    localparam int DVD_W    = 40;
    localparam int DVS_W    = 23;
    localparam int QUO_W    = 25;
    localparam int CNT_W    = 5;
    localparam int SLOPE_W  = QUO_W;
    localparam int RECIP_W  = QUO_W;
    localparam int RECIP_SH = 24;
    localparam int OFF_W    = U_W + FRAC_W;
    localparam int PROD_W   = OFF_W + SLOPE_W + 1;
    localparam int LPROD_W  = 2 * PIX_W + RECIP_W;
    localparam int NSTG     = 5;

    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEG3   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SEG4   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SEG5   = 2'd3;

    localparam logic [IDX_W-1:0] REG_RED_MIN   = 3'd0;
    localparam logic [IDX_W-1:0] REG_RED_MAX   = 3'd1;
    localparam logic [IDX_W-1:0] REG_GREEN_MIN = 3'd2;
    localparam logic [IDX_W-1:0] REG_GREEN_MAX = 3'd3;
    localparam logic [IDX_W-1:0] REG_BLUE_MIN  = 3'd4;
    localparam logic [IDX_W-1:0] REG_BLUE_MAX  = 3'd5;
    localparam logic [IDX_W-1:0] REG_MODE      = 3'd6;

    localparam logic [PIX_W-1:0] PIX_MAX   = 8'hFF;
    localparam logic [KF_W-1:0]  KF_ONE    = 24'h010000;
    localparam logic [DVS_W-1:0] FOLD_ONE  = 23'h010000;
    localparam logic [DVS_W-1:0] FOLD_TWO  = 23'h020000;
    localparam logic [DVD_W-1:0] RECIP_NUM = 40'h0001000000;

    typedef struct packed {
        logic [PIX_W-1:0] red_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] blue_in;
    } rpcs_pix_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] red_out;
        logic [PIX_W-1:0] green_out;
        logic [PIX_W-1:0] blue_out;
    } rpcs_pix_out_t;

    // per-channel coefficients, stable while the setup is idle
    typedef struct packed {
        logic [SEG_N-1:0][KF_W-1:0]    kf;
        logic [SEG_N-1:0][SLOPE_W-1:0] slope;
        logic [RECIP_W-1:0]            recip;
        logic                          den_zero;
        logic                          den_neg;
    } rpcs_coef_t;

    function automatic logic [PIX_W-1:0] slope_const(input logic [MODE_W-1:0] mode,
                                                    input logic [SEG_W-1:0] k);
        logic [PIX_W-1:0] c;
        c = '0;
        case (mode)
            MODE_SEG3: begin
                case (k)
                    3'd0: c = 8'd63;
                    3'd1: c = 8'd128;
                    3'd2: c = 8'd64;
                    default: c = '0;
                endcase
            end
            MODE_SEG4: begin
                case (k)
                    3'd0: c = 8'd31;
                    3'd1: c = 8'd96;
                    3'd2: c = 8'd96;
                    3'd3: c = 8'd32;
                    default: c = '0;
                endcase
            end
            MODE_SEG5: begin
                case (k)
                    3'd0: c = 8'd15;
                    3'd1: c = 8'd64;
                    3'd2: c = 8'd96;
                    3'd3: c = 8'd64;
                    3'd4: c = 8'd16;
                    default: c = '0;
                endcase
            end
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [PIX_W-1:0] base_const(input logic [MODE_W-1:0] mode,
                                                   input logic [SEG_W-1:0] k);
        logic [PIX_W-1:0] b;
        b = '0;
        case (mode)
            MODE_SEG3: begin
                case (k)
                    3'd1: b = 8'd63;
                    3'd2: b = 8'd191;
                    default: b = '0;
                endcase
            end
            MODE_SEG4: begin
                case (k)
                    3'd1: b = 8'd31;
                    3'd2: b = 8'd127;
                    3'd3: b = 8'd191;
                    default: b = '0;
                endcase
            end
            MODE_SEG5: begin
                case (k)
                    3'd1: b = 8'd15;
                    3'd2: b = 8'd79;
                    3'd3: b = 8'd175;
                    3'd4: b = 8'd239;
                    default: b = '0;
                endcase
            end
            default: b = '0;
        endcase
        return b;
    endfunction

endpackage

// ----- hdl/rpcs_div.sv -----
`timescale 1ns / 1ps

module rpcs_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [rpcs_pkg::DVD_W-1:0]  dividend,
    input  logic [rpcs_pkg::DVS_W-1:0]  divisor,
    output logic                        done,
    output logic [rpcs_pkg::QUO_W-1:0]  quotient
);
    import rpcs_pkg::*;

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DVS_W-1:0]   rem_reg;
    logic [QUO_W-1:0]   sh_reg;
    logic [DVS_W-1:0]   dvs_reg;
    logic [DVS_W:0]     rem_sh;
    logic [DVS_W:0]     diff;
    logic               ge;

    // quotient is known to fit QUO_W bits, so the top dividend bits seed the remainder
    assign rem_sh = {rem_reg, sh_reg[QUO_W-1]};
    assign diff   = rem_sh - {1'b0, dvs_reg};
    assign ge     = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QUO_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= DVS_W'(dividend[DVD_W-1:QUO_W]);
            sh_reg  <= dividend[QUO_W-1:0];
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            sh_reg  <= {sh_reg[QUO_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = sh_reg;

endmodule

// ----- hdl/rpcs_setup.sv -----
`timescale 1ns / 1ps

module rpcs_setup (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         restart,
    input  logic [rpcs_pkg::MODE_W-1:0]  mode,
    input  logic [rpcs_pkg::PIX_W-1:0]   mn,
    input  logic [rpcs_pkg::PIX_W-1:0]   mx,
    output logic                         ready,
    output rpcs_pkg::rpcs_coef_t         coef
);
    import rpcs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FOLD  = 4'b0010,
        ST_SLOPE = 4'b0100,
        ST_RECIP = 4'b1000
    } rpcs_st_t;

    rpcs_st_t                       st_reg;
    logic [SEG_W-1:0]               k_reg;
    logic                           go_reg;
    logic [DVS_W-1:0]               fold_reg;
    logic [SEG_N-1:1][KF_W-1:0]     kf_reg;
    logic [SEG_N-1:0][SLOPE_W-1:0]  slope_reg;
    logic [RECIP_W-1:0]             recip_reg;

    logic [SEG_W-1:0]   segs;
    logic [SEG_W-1:0]   last_k;
    logic [PIX_W:0]     d9;
    logic [PIX_W-1:0]   b;
    logic [DVS_W-1:0]   den0;
    logic [DVD_W-1:0]   dividend;
    logic [DVS_W-1:0]   divisor;
    logic               div_start;
    logic               div_done;
    logic [QUO_W-1:0]   quotient;
    logic               accept;
    logic [DVS_W-1:0]   q_fold;

    assign segs   = SEG_W'(mode) + SEG_W'(2);
    assign last_k = segs - SEG_W'(1);
    assign d9     = {1'b0, mx} - {1'b0, mn} + (PIX_W + 1)'(1);
    assign b      = (mx >= mn) ? (mx - mn) : (mn - mx);
    assign den0   = fold_reg - FOLD_ONE;
    assign q_fold = quotient[DVS_W-1:0];

    always_comb begin
        dividend = '0;
        divisor  = DVS_W'(1);
        case (st_reg)
            ST_FOLD: begin
                dividend = DVD_W'({d9, {FRAC_W{1'b0}}});
                divisor  = DVS_W'(segs);
            end
            ST_SLOPE: begin
                dividend = {slope_const(mode, k_reg), {QPOS{1'b0}}};
                divisor  = (k_reg == '0) ? den0 : fold_reg;
            end
            ST_RECIP: begin
                dividend = RECIP_NUM + DVD_W'(b) - DVD_W'(1);
                divisor  = DVS_W'(b);
            end
            default: begin
                dividend = '0;
                divisor  = DVS_W'(1);
            end
        endcase
    end

    assign div_start = go_reg && (st_reg != ST_IDLE);
    assign accept    = div_done && !go_reg;

    rpcs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            st_reg <= ST_FOLD;
            k_reg  <= '0;
            go_reg <= 1'b1;
        end else begin
            if (div_start) begin
                go_reg <= 1'b0;
            end
            if (accept) begin
                case (st_reg)
                    ST_FOLD: begin
                        st_reg <= ST_SLOPE;
                        k_reg  <= '0;
                        go_reg <= 1'b1;
                    end
                    ST_SLOPE: begin
                        go_reg <= 1'b1;
                        if (k_reg == last_k) begin
                            st_reg <= ST_RECIP;
                        end else begin
                            k_reg <= k_reg + 1'b1;
                        end
                    end
                    ST_RECIP: begin
                        st_reg <= ST_IDLE;
                    end
                    default: begin
                        st_reg <= ST_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && (st_reg == ST_FOLD)) begin
            fold_reg  <= q_fold;
            kf_reg[1] <= KF_W'(q_fold);
            kf_reg[2] <= KF_W'({q_fold, 1'b0});
            kf_reg[3] <= KF_W'({q_fold, 1'b0}) + KF_W'(q_fold);
            kf_reg[4] <= KF_W'({q_fold, 2'b00});
        end
        // first segment slope only matters once the first fold spans more than one level
        if (accept && (st_reg == ST_SLOPE)) begin
            slope_reg[k_reg] <= ((k_reg == '0) && (fold_reg < FOLD_TWO)) ?
                                '0 : quotient[SLOPE_W-1:0];
        end
        if (accept && (st_reg == ST_RECIP)) begin
            recip_reg <= quotient[RECIP_W-1:0];
        end
    end

    always_comb begin
        coef.kf[0] = KF_ONE;
        for (int i = 1; i < SEG_N; i++) begin
            coef.kf[i] = kf_reg[i];
        end
        coef.slope    = slope_reg;
        coef.recip    = recip_reg;
        coef.den_zero = (mx == mn);
        coef.den_neg  = (mx < mn);
    end

    assign ready = (st_reg == ST_IDLE);

endmodule

// ----- hdl/rpcs_chan.sv -----
`timescale 1ns / 1ps

module rpcs_chan (
    input  logic                         aclk,
    input  logic [rpcs_pkg::NSTG-1:0]    en,
    input  logic [rpcs_pkg::PIX_W-1:0]   x,
    input  logic [rpcs_pkg::MODE_W-1:0]  mode,
    input  logic [rpcs_pkg::PIX_W-1:0]   mn,
    input  rpcs_pkg::rpcs_coef_t         coef,
    output logic [rpcs_pkg::PIX_W-1:0]   y
);
    import rpcs_pkg::*;

    // stage 0
    logic [U_W-1:0]             u_s0_reg;
    logic [PIX_W:0]             a_s0_reg;
    // stage 1
    logic [U_W-1:0]             u_s1_reg;
    logic [SEG_W-1:0]           seg_s1_reg;
    logic [PIX_W-1:0]           aabs_s1_reg;
    logic                       lz_s1_reg;
    // stage 2
    logic [OFF_W-1:0]           off_s2_reg;
    logic [SLOPE_W-1:0]         slope_s2_reg;
    logic [PIX_W-1:0]           base_s2_reg;
    logic [2*PIX_W-1:0]         n_s2_reg;
    logic                       lz_s2_reg;
    // stage 3
    logic signed [PROD_W-1:0]   prod_s3_reg;
    logic [LPROD_W-1:0]         lp_s3_reg;
    logic [PIX_W-1:0]           base_s3_reg;
    logic                       lz_s3_reg;
    // stage 4
    logic [PIX_W-1:0]           y_reg;

    logic [U_W-1:0]     u_next;
    logic [PIX_W:0]     a_next;
    logic [SEG_W-1:0]   segs;
    logic [SEG_W-1:0]   cnt;
    logic               u_pos;
    logic [SEG_W-1:0]   seg_next;
    logic [PIX_W:0]     a_neg;
    logic               lz_next;
    logic [OFF_W-1:0]   off_next;
    logic [PROD_W-1:0]  v;
    logic [PIX_W-1:0]   pw_out;
    logic [PIX_W-1:0]   lin_out;
    logic [PIX_W-1:0]   y_next;

    assign u_next = {2'b00, x} - {2'b00, mn} + U_W'(1);
    assign a_next = {1'b0, x} - {1'b0, mn};

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            u_s0_reg <= u_next;
            a_s0_reg <= a_next;
        end
    end

    // segment = number of breakpoints passed; offsets below min land in the last one
    assign segs  = SEG_W'(mode) + SEG_W'(2);
    assign u_pos = !u_s0_reg[U_W-1] && (u_s0_reg != '0);

    always_comb begin
        cnt = '0;
        for (int j = 1; j < SEG_N; j++) begin
            if ((SEG_W'(j) < segs) &&
                ($signed(u_s0_reg) > $signed({2'b00, coef.kf[j][KF_W-1:FRAC_W]}))) begin
                cnt = cnt + 1'b1;
            end
        end
    end

    assign seg_next = u_pos ? cnt : (segs - SEG_W'(1));
    assign a_neg    = -a_s0_reg;
    assign lz_next  = (a_s0_reg == '0) || coef.den_zero || (a_s0_reg[PIX_W] != coef.den_neg);

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            u_s1_reg    <= u_s0_reg;
            seg_s1_reg  <= seg_next;
            aabs_s1_reg <= a_s0_reg[PIX_W] ? a_neg[PIX_W-1:0] : a_s0_reg[PIX_W-1:0];
            lz_s1_reg   <= lz_next;
        end
    end

    assign off_next = {u_s1_reg, {FRAC_W{1'b0}}} - {2'b00, coef.kf[seg_s1_reg]};

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            off_s2_reg   <= off_next;
            slope_s2_reg <= coef.slope[seg_s1_reg];
            base_s2_reg  <= base_const(mode, seg_s1_reg);
            n_s2_reg     <= {aabs_s1_reg, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, aabs_s1_reg};
            lz_s2_reg    <= lz_s1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            prod_s3_reg <= $signed(off_s2_reg) * $signed({1'b0, slope_s2_reg});
            lp_s3_reg   <= n_s2_reg * coef.recip;
            base_s3_reg <= base_s2_reg;
            lz_s3_reg   <= lz_s2_reg;
        end
    end

    assign v = prod_s3_reg + PROD_W'({base_s3_reg, {QPOS{1'b0}}});

    always_comb begin
        if (v[PROD_W-1]) begin
            pw_out = '0;
        end else if (|v[PROD_W-2:QPOS+PIX_W]) begin
            pw_out = PIX_MAX;
        end else begin
            pw_out = v[QPOS+PIX_W-1:QPOS];
        end

        if (lz_s3_reg) begin
            lin_out = '0;
        end else if (|lp_s3_reg[LPROD_W-1:RECIP_SH+PIX_W]) begin
            lin_out = PIX_MAX;
        end else begin
            lin_out = lp_s3_reg[RECIP_SH+PIX_W-1:RECIP_SH];
        end

        if (mode == MODE_LINEAR) begin
            y_next = lin_out;
        end else if (coef.den_neg) begin
            y_next = '0;
        end else begin
            y_next = pw_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

// ----- hdl/rgb_piecewise_contrast_stretch.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake                    Payload
// s_        in         s_valid / s_ready            s_data  (red_in, green_in, blue_in)
// m_        out        m_valid / m_ready            m_data  (red_out, green_out, blue_out)
// cfg_      in         cfg_valid / cfg_ready        cfg_index, cfg_data
//
// Five register stages, the last driving m_valid; one item per cycle unless m_ready or
// setup stalls. After reset and after every cfg write, each channel runs up to seven
// 25-step divisions for its fold, slopes and reciprocal; s_ready stays low until done.
// Reset is synchronous, active low. Each stage moves when the one after it is empty or
// moving, so bubbles fill and a stall on m_ready loses or repeats nothing.

module rgb_piecewise_contrast_stretch (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  rpcs_pkg::rpcs_pix_in_t       s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output rpcs_pkg::rpcs_pix_out_t      m_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rpcs_pkg::IDX_W-1:0]   cfg_index,
    input  logic [rpcs_pkg::PIX_W-1:0]   cfg_data
);
    import rpcs_pkg::*;

    logic [PIX_W-1:0]   red_min_reg;
    logic [PIX_W-1:0]   red_max_reg;
    logic [PIX_W-1:0]   green_min_reg;
    logic [PIX_W-1:0]   green_max_reg;
    logic [PIX_W-1:0]   blue_min_reg;
    logic [PIX_W-1:0]   blue_max_reg;
    logic [MODE_W-1:0]  mode_reg;
    logic [NSTG-1:0]    v_reg;

    logic               cfg_wr;
    logic [NSTG-1:0]    rdy;
    logic [NCH-1:0]     setup_rdy;
    logic [NCH-1:0][PIX_W-1:0] ch_min;
    logic [NCH-1:0][PIX_W-1:0] ch_max;
    logic [NCH-1:0][PIX_W-1:0] ch_x;
    logic [NCH-1:0][PIX_W-1:0] ch_y;
    rpcs_coef_t         ch_coef [NCH];

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_min_reg   <= '0;
            red_max_reg   <= PIX_MAX;
            green_min_reg <= '0;
            green_max_reg <= PIX_MAX;
            blue_min_reg  <= '0;
            blue_max_reg  <= PIX_MAX;
            mode_reg      <= MODE_SEG5;
        end else if (cfg_wr) begin
            case (cfg_index)
                REG_RED_MIN:   red_min_reg   <= cfg_data;
                REG_RED_MAX:   red_max_reg   <= cfg_data;
                REG_GREEN_MIN: green_min_reg <= cfg_data;
                REG_GREEN_MAX: green_max_reg <= cfg_data;
                REG_BLUE_MIN:  blue_min_reg  <= cfg_data;
                REG_BLUE_MAX:  blue_max_reg  <= cfg_data;
                REG_MODE:      mode_reg      <= cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    assign ch_min[0] = red_min_reg;
    assign ch_max[0] = red_max_reg;
    assign ch_x[0]   = s_data.red_in;
    assign ch_min[1] = green_min_reg;
    assign ch_max[1] = green_max_reg;
    assign ch_x[1]   = s_data.green_in;
    assign ch_min[2] = blue_min_reg;
    assign ch_max[2] = blue_max_reg;
    assign ch_x[2]   = s_data.blue_in;

    always_comb begin
        rdy[NSTG-1] = !v_reg[NSTG-1] || m_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign s_ready = rdy[0] && (&setup_rdy);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= s_valid && s_ready;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (rdy[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    for (genvar c = 0; c < NCH; c++) begin : g_ch
        rpcs_setup u_setup (
            .aclk    (aclk),
            .aresetn (aresetn),
            .restart (cfg_wr),
            .mode    (mode_reg),
            .mn      (ch_min[c]),
            .mx      (ch_max[c]),
            .ready   (setup_rdy[c]),
            .coef    (ch_coef[c])
        );

        rpcs_chan u_chan (
            .aclk (aclk),
            .en   (rdy),
            .x    (ch_x[c]),
            .mode (mode_reg),
            .mn   (ch_min[c]),
            .coef (ch_coef[c]),
            .y    (ch_y[c])
        );
    end

    assign m_valid          = v_reg[NSTG-1];
    assign m_data.red_out   = ch_y[0];
    assign m_data.green_out = ch_y[1];
    assign m_data.blue_out  = ch_y[2];

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

import rpcs_pkg::*;

class stretch_scoreboard;
    int                lo_bound [NCH];
    int                hi_bound [NCH];
    logic [MODE_W-1:0] mode;
    rpcs_pix_out_t     expected_q [$];
    int                errors;
    int                checked;

    function new();
        for (int c = 0; c < NCH; c++) begin
            lo_bound[c] = 0;
            hi_bound[c] = 255;
        end
        mode    = MODE_SEG5;
        errors  = 0;
        checked = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [PIX_W-1:0] data);
        case (idx)
            REG_RED_MIN:   lo_bound[0] = data;
            REG_RED_MAX:   hi_bound[0] = data;
            REG_GREEN_MIN: lo_bound[1] = data;
            REG_GREEN_MAX: hi_bound[1] = data;
            REG_BLUE_MIN:  lo_bound[2] = data;
            REG_BLUE_MAX:  hi_bound[2] = data;
            REG_MODE:      mode = data[MODE_W-1:0];
            default: ;
        endcase
    endfunction

    function longint clamp_q32(longint v);
        longint r;
        if (v < 0)
            return 0;
        r = v >>> 32;
        return (r > 255) ? 255 : r;
    endfunction

    function int linear_map(int x, int mn, int mx);
        int den;
        int q;
        den = mx - mn;
        if (den == 0)
            return 0;
        q = ((x - mn) * 255) / den;
        if (q < 0)
            return 0;
        return (q > 255) ? 255 : q;
    endfunction

    function int piece_map(longint x, longint mn, longint mx);
        logic [119:0] slope_tab;
        logic [119:0] base_tab;
        longint       segs, fold, xq, lo_q, slope, off, cs, cb;
        int           k, sel;
        // byte (mode-1)*5+k, five segments at the top
        slope_tab = {8'd16, 8'd64, 8'd96, 8'd64, 8'd15,
                     8'd0,  8'd32, 8'd96, 8'd96, 8'd31,
                     8'd0,  8'd0,  8'd64, 8'd128, 8'd63};
        base_tab  = {8'd239, 8'd175, 8'd79,  8'd15, 8'd0,
                     8'd0,   8'd191, 8'd127, 8'd31, 8'd0,
                     8'd0,   8'd0,   8'd191, 8'd63, 8'd0};
        segs = longint'(mode) + 2;
        if (mx < mn)
            return 0;
        fold = ((mx - mn + 1) * 65536) / segs;
        xq   = x * 65536;
        lo_q = mn * 65536;
        if (xq >= lo_q && xq <= lo_q + fold - 65536) begin
            if (fold <= 65536)
                return 0;
            cs    = slope_tab[(int'(mode) - 1) * 40 +: 8];
            slope = (cs << 32) / (fold - 65536);
            return int'(clamp_q32(slope * ((x - mn) << 16)));
        end
        k = int'(segs - 1);
        for (int j = 1; j <= segs - 2; j++) begin
            if (xq > lo_q + j * fold - 65536 && xq <= lo_q + (j + 1) * fold - 65536)
                k = j;
        end
        sel   = ((int'(mode) - 1) * 5 + k) * 8;
        cs    = slope_tab[sel +: 8];
        cb    = base_tab[sel +: 8];
        slope = (cs << 32) / fold;
        off   = (x - mn + 1) * 65536 - k * fold;
        return int'(clamp_q32(slope * off + (cb << 32)));
    endfunction

    function logic [PIX_W-1:0] map_chan(logic [PIX_W-1:0] x, int c);
        if (mode == MODE_LINEAR)
            return PIX_W'(linear_map(x, lo_bound[c], hi_bound[c]));
        return PIX_W'(piece_map(x, lo_bound[c], hi_bound[c]));
    endfunction

    function void note_pixel(rpcs_pix_in_t p);
        rpcs_pix_out_t r;
        r.red_out   = map_chan(p.red_in, 0);
        r.green_out = map_chan(p.green_in, 1);
        r.blue_out  = map_chan(p.blue_in, 2);
        expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    function void check_pixel(rpcs_pix_out_t got);
        rpcs_pix_out_t want;
        if (expected_q.size() == 0) begin
            $error("unexpected item: red_out %0d green_out %0d blue_out %0d",
                   got.red_out, got.green_out, got.blue_out);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        checked++;
        compare_field("red_out", want.red_out, got.red_out);
        compare_field("green_out", want.green_out, got.green_out);
        compare_field("blue_out", want.blue_out, got.blue_out);
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module tb;
    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int HOLD_CYCLES = 400;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    rpcs_pix_in_t       s_data    = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    rpcs_pix_out_t      m_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [IDX_W-1:0]   cfg_index = '0;
    logic [PIX_W-1:0]   cfg_data  = '0;

    bit tx_idle  = 1'b1;
    bit rx_idle  = 1'b1;
    bit hold_req = 1'b0;
    int n_settings = 0;
    int cur_lo [NCH];
    int cur_hi [NCH];

    stretch_scoreboard sb = new();

    rgb_piecewise_contrast_stretch dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready)
                sb.note_pixel(s_data);
            if (m_valid && m_ready)
                sb.check_pixel(m_data);
        end
    end

    // output side: random stalls, plus one long hold on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (rx_idle && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [PIX_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic configure(input int rl, input int rh, input int gl, input int gh,
                             input int bl, input int bh, input logic [MODE_W-1:0] md);
        logic [PIX_W-MODE_W-1:0] junk;
        junk = (PIX_W - MODE_W)'($urandom);
        put_reg(REG_RED_MIN, PIX_W'(rl));
        put_reg(REG_RED_MAX, PIX_W'(rh));
        put_reg(REG_GREEN_MIN, PIX_W'(gl));
        put_reg(REG_GREEN_MAX, PIX_W'(gh));
        put_reg(REG_BLUE_MIN, PIX_W'(bl));
        put_reg(REG_BLUE_MAX, PIX_W'(bh));
        put_reg(REG_UNUSED, PIX_W'($urandom_range(0, 255)));
        put_reg(REG_MODE, {junk, md});
        cfg_valid <= 1'b0;
        cur_lo[0] = rl; cur_hi[0] = rh;
        cur_lo[1] = gl; cur_hi[1] = gh;
        cur_lo[2] = bl; cur_hi[2] = bh;
        n_settings++;
    endtask

    task automatic send_pixel(input rpcs_pix_in_t p);
        s_valid <= 1'b1;
        s_data  <= p;
        do @(posedge aclk); while (!s_ready);
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function automatic rpcs_pix_in_t px(input int r, input int g, input int b);
        rpcs_pix_in_t p;
        p.red_in   = PIX_W'(r);
        p.green_in = PIX_W'(g);
        p.blue_in  = PIX_W'(b);
        return p;
    endfunction

    function automatic logic [PIX_W-1:0] pick_chan(input int lo, input int hi);
        case ($urandom_range(0, 9))
            0, 1, 2: return PIX_W'($urandom_range(0, 255));
            3: begin
                case ($urandom_range(0, 5))
                    0: return '0;
                    1: return PIX_MAX;
                    2: return PIX_W'(lo);
                    3: return PIX_W'(hi);
                    4: return PIX_W'(lo - 1);
                    default: return PIX_W'(hi + 1);
                endcase
            end
            default: return PIX_W'($urandom_range(lo, hi));
        endcase
    endfunction

    function automatic rpcs_pix_in_t pick_pixel();
        return px(pick_chan(cur_lo[0], cur_hi[0]), pick_chan(cur_lo[1], cur_hi[1]),
                  pick_chan(cur_lo[2], cur_hi[2]));
    endfunction

    task automatic pick_bounds(output int lo, output int hi);
        case ($urandom_range(0, 9))
            0: begin
                lo = 0;
                hi = 255;
            end
            1: begin
                lo = $urandom_range(0, 255);
                hi = lo;
            end
            2: begin
                hi = $urandom_range(0, 254);
                lo = $urandom_range(hi + 1, 255);
            end
            3: begin
                lo = $urandom_range(0, 250);
                hi = lo + $urandom_range(1, 5);
            end
            4: begin
                lo = 0;
                hi = $urandom_range(1, 255);
            end
            5: begin
                lo = $urandom_range(0, 254);
                hi = 255;
            end
            default: begin
                lo = $urandom_range(0, 254);
                hi = $urandom_range(lo + 1, 255);
            end
        endcase
    endtask

    initial begin
        int                lo [NCH];
        int                hi [NCH];
        logic [MODE_W-1:0] md;
        int                guard;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // settings out of reset: five segments over 0..255
        send_pixel(px(0, 0, 0));
        send_pixel(px(255, 255, 255));
        send_pixel(px(50, 51, 153));
        send_pixel(px(204, 205, 128));
        drain();

        // linear: equal bounds, normal, inverted
        configure(100, 100, 10, 200, 200, 50, MODE_LINEAR);
        send_pixel(px(100, 5, 0));
        send_pixel(px(0, 200, 255));
        send_pixel(px(255, 105, 125));
        drain();

        // three segments: inverted, fold under one, input below min
        configure(200, 100, 50, 50, 100, 200, MODE_SEG3);
        send_pixel(px(150, 50, 20));
        send_pixel(px(0, 49, 100));
        send_pixel(px(255, 51, 255));
        drain();

        // four segments: fold of exactly one on green
        configure(0, 255, 0, 3, 1, 254, MODE_SEG4);
        send_pixel(px(0, 0, 0));
        send_pixel(px(63, 1, 64));
        send_pixel(px(64, 3, 191));
        send_pixel(px(255, 255, 255));
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            for (int c = 0; c < NCH; c++)
                pick_bounds(lo[c], hi[c]);
            if (ph == 0 || ph == 7) begin
                for (int c = 0; c < NCH; c++) begin
                    lo[c] = 0;
                    hi[c] = 255;
                end
            end
            md = (ph < 8) ? MODE_W'(ph % 4) : MODE_W'($urandom_range(0, 3));
            if (ph == 9) begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end
            configure(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2], md);
            if (ph == 5) begin
                tx_idle = 1'b0;
                send_pixel(pick_pixel());
                hold_req = 1'b1;
                repeat (49) send_pixel(pick_pixel());
            end else begin
                repeat (50) send_pixel(pick_pixel());
            end
            drain();
            if (ph == 5)
                tx_idle = 1'b1;
        end

        guard = 0;
        while (sb.pending() > 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (20) @(posedge aclk);
        if (sb.pending() > 0)
            $error("%0d expected items never arrived", sb.pending());
        $display("Checked %0d pixels over %0d register settings in all four stretch modes,",
                 sb.checked, n_settings);
        $display("with stalls on both sides and one long output hold.");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// ----- filelist.f -----
hdl/rpcs_pkg.sv
hdl/rpcs_div.sv
hdl/rpcs_setup.sv
hdl/rpcs_chan.sv
hdl/rgb_piecewise_contrast_stretch.sv
tb/tb.sv
